[src/mmr_pkg.sv]
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared types, widths and codes for the row-streaming matrix multiply core.
// ----------------------------------------------------------------------------
package mmr_pkg;

	localparam int MAX_INNER_DEF = 256;
	localparam int MAX_COLS_DEF  = 16;

	localparam int ROW_W   = 8;
	localparam int COL_W   = 4;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = 40;

	localparam int INNER_LEN_W = 9;
	localparam int OUT_COLS_W  = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	localparam logic [INNER_LEN_W-1:0] INNER_LEN_RST = 9'd256;
	localparam logic [OUT_COLS_W-1:0]  OUT_COLS_RST  = 5'd16;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_FEED = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_LEN = 1'b0,
		REG_OUT_COLS  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic feed;
		logic last;
	} mmr_ctrl_t;

endpackage

[src/mmr_if.sv]
// ----------------------------------------------------------------------------
// mmr channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface mmr_in_if;
	logic                            valid;
	logic                            ready;
	logic                            cmd;
	logic [mmr_pkg::ROW_W-1:0]       inner_index;
	logic [mmr_pkg::COL_W-1:0]       col_index;
	logic signed [mmr_pkg::ELEM_W-1:0] elem_value;

	modport source (output valid, cmd, inner_index, col_index, elem_value, input ready);
	modport sink (input valid, cmd, inner_index, col_index, elem_value, output ready);
endinterface

interface mmr_out_if;
	logic                             valid;
	logic                             ready;
	logic [mmr_pkg::COL_W-1:0]        out_col;
	logic signed [mmr_pkg::SUM_W-1:0] dot_sum;
	logic                             row_last;

	modport source (output valid, out_col, dot_sum, row_last, input ready);
	modport sink (input valid, out_col, dot_sum, row_last, output ready);
endinterface

interface mmr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mmr_pkg::CFG_IDX_W-1:0]   index;
	logic [mmr_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/matrix_multiply_rowstream_core.sv]
// a row's first sum is valid once its last element passes ctrl_s1, ctrl_s2, busy_q
// throughput: one load or A element per cycle; after a row's last element the input
//   stalls until the column sums have drained, one per cycle while dout.ready is high
// reset: inner_len = 256, out_cols = 16, column accumulators and pipeline cleared;
//   the weight RAMs are not cleared and must be loaded before use
// ----------------------------------------------------------------------------
// matrix_multiply_rowstream_core
// Streaming A x B: weights in per-column RAMs, one MAC lane per column.
// ----------------------------------------------------------------------------
module matrix_multiply_rowstream_core #(
	parameter int MAX_INNER = mmr_pkg::MAX_INNER_DEF,
	parameter int MAX_COLS  = mmr_pkg::MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mmr_in_if.sink     din,
	mmr_out_if.source  dout,
	mmr_cfg_if.sink    cfg
);

	localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int IW = ($clog2(MAX_INNER + 1) > mmr_pkg::INNER_LEN_W) ?
		$clog2(MAX_INNER + 1) : mmr_pkg::INNER_LEN_W;
	localparam int CW = ($clog2(MAX_COLS + 1) > mmr_pkg::OUT_COLS_W) ?
		$clog2(MAX_COLS + 1) : mmr_pkg::OUT_COLS_W;

	logic [mmr_pkg::INNER_LEN_W-1:0] inner_len_q;
	logic [mmr_pkg::OUT_COLS_W-1:0]  out_cols_q;
	logic [IW-1:0]                   eff_ni;
	logic [CW-1:0]                   eff_nc;

	logic                            in_xfer;
	logic                            row_ok;
	logic                            is_feed;
	logic                            is_last;
	logic                            load_ok;
	logic [AW-1:0]                   row_addr;

	mmr_pkg::mmr_ctrl_t              ctrl_s1;
	mmr_pkg::mmr_ctrl_t              ctrl_s2;
	logic signed [mmr_pkg::ELEM_W-1:0] value_s1;

	logic [MAX_COLS-1:0][mmr_pkg::ELEM_W-1:0] weight_s1;
	logic [MAX_COLS-1:0][mmr_pkg::SUM_W-1:0]  lane_sum;
	logic [MAX_COLS-1:0]                      col_en;
	logic                                     busy;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_len_q <= mmr_pkg::INNER_LEN_RST;
			out_cols_q  <= mmr_pkg::OUT_COLS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				mmr_pkg::REG_INNER_LEN: inner_len_q <= cfg.data;
				mmr_pkg::REG_OUT_COLS:  out_cols_q  <= mmr_pkg::OUT_COLS_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// clamped sizes
	always_comb begin
		if (inner_len_q == '0) begin
			eff_ni = IW'(1);
		end else if (IW'(inner_len_q) > IW'(MAX_INNER)) begin
			eff_ni = IW'(MAX_INNER);
		end else begin
			eff_ni = IW'(inner_len_q);
		end
		if (out_cols_q == '0) begin
			eff_nc = CW'(1);
		end else if (CW'(out_cols_q) > CW'(MAX_COLS)) begin
			eff_nc = CW'(MAX_COLS);
		end else begin
			eff_nc = CW'(out_cols_q);
		end
	end

	// input decode
	assign din.ready = !(busy || ctrl_s1.last || ctrl_s2.last);
	assign in_xfer   = din.valid && din.ready;
	assign row_ok    = IW'(din.inner_index) < eff_ni;
	assign is_feed   = in_xfer && (din.cmd == mmr_pkg::CMD_FEED) && row_ok;
	assign is_last   = is_feed && (IW'(din.inner_index) == (eff_ni - IW'(1)));
	assign load_ok   = in_xfer && (din.cmd == mmr_pkg::CMD_LOAD) && row_ok &&
		(CW'(din.col_index) < eff_nc);
	assign row_addr  = AW'(din.inner_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= '{feed: is_feed, last: is_last};
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		value_s1 <= din.elem_value;
	end

	// one weight RAM and one MAC lane per column
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		assign col_en[c] = CW'(c) < eff_nc;

		mmr_ram #(
			.WIDTH (mmr_pkg::ELEM_W),
			.DEPTH (MAX_INNER)
		) u_wram (
			.clk     (clk),
			.we      (load_ok && (CW'(din.col_index) == CW'(c))),
			.waddr   (row_addr),
			.wdata   (din.elem_value),
			.raddr   (row_addr),
			.rdata_q (weight_s1[c])
		);

		mmr_mac_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.value_s1  (value_s1),
			.weight_s1 (weight_s1[c]),
			.ctrl_s2   (ctrl_s2),
			.col_en    (col_en[c]),
			.row_sum   (lane_sum[c])
		);
	end

	mmr_emit #(
		.MAX_COLS (MAX_COLS),
		.CW       (CW)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (ctrl_s2.last),
		.sums    (lane_sum),
		.eff_nc  (eff_nc),
		.busy    (busy),
		.dout    (dout)
	);

	a_last_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s2.last |=> dout.valid && (dout.out_col == '0))
		else $error("row end did not start a result burst at column zero");

	a_row_end_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl_s1.last, ctrl_s2.last, busy}))
		else $error("two row ends in flight at once");

	a_no_take_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !busy)
		else $error("input transfer while result row is draining");

endmodule

[src/mmr_ram.sv]
// ----------------------------------------------------------------------------
// mmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

[src/mmr_mac_lane.sv]
// ----------------------------------------------------------------------------
// mmr_mac_lane
// One column: registered product, then accumulate or hand off the row sum.
// ----------------------------------------------------------------------------
module mmr_mac_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [mmr_pkg::ELEM_W-1:0] value_s1,
	input  logic signed [mmr_pkg::ELEM_W-1:0] weight_s1,
	input  mmr_pkg::mmr_ctrl_t                ctrl_s2,
	input  logic                              col_en,
	output logic [mmr_pkg::SUM_W-1:0]         row_sum
);

	logic signed [mmr_pkg::PROD_W-1:0] prod_s2;
	logic [mmr_pkg::SUM_W-1:0]         acc_q;
	logic [mmr_pkg::SUM_W-1:0]         prod_ext;

	always_ff @(posedge clk) begin
		prod_s2 <= value_s1 * weight_s1;
	end

	assign prod_ext = {{(mmr_pkg::SUM_W - mmr_pkg::PROD_W){prod_s2[mmr_pkg::PROD_W-1]}}, prod_s2};
	assign row_sum  = acc_q + prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl_s2.feed && col_en) begin
			if (ctrl_s2.last) begin
				acc_q <= '0;
			end else begin
				acc_q <= row_sum;
			end
		end
	end

endmodule

[src/mmr_emit.sv]
// ----------------------------------------------------------------------------
// mmr_emit
// Holds a finished row of sums and sends them out one column per transfer.
// ----------------------------------------------------------------------------
module mmr_emit #(
	parameter int MAX_COLS = mmr_pkg::MAX_COLS_DEF,
	parameter int CW = 5,
	localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      capture,
	input  logic [MAX_COLS-1:0][mmr_pkg::SUM_W-1:0]   sums,
	input  logic [CW-1:0]                             eff_nc,
	output logic                                      busy,
	mmr_out_if.source                                 dout
);

	logic [MAX_COLS-1:0][mmr_pkg::SUM_W-1:0] bank_q;
	logic                                    busy_q;
	logic [XW-1:0]                           idx_q;
	logic                                    at_last;
	logic                                    xfer;

	assign at_last = (CW'(idx_q) == (eff_nc - CW'(1)));
	assign xfer    = busy_q && dout.ready;

	always_ff @(posedge clk) begin
		if (capture) begin
			bank_q <= sums;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (capture) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			if (at_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + XW'(1);
			end
		end
	end

	assign busy          = busy_q;
	assign dout.valid    = busy_q;
	assign dout.out_col  = mmr_pkg::COL_W'(idx_q);
	assign dout.dot_sum  = bank_q[idx_q];
	assign dout.row_last = at_last;

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && dout.row_last |=> !dout.valid)
		else $error("result burst continues after final column");

	a_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && !dout.row_last |=>
			dout.valid && (dout.out_col == $past(dout.out_col) + mmr_pkg::COL_W'(1)))
		else $error("result column did not advance by one");

	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		capture |-> !busy_q)
		else $error("row sums captured while previous row still draining");

endmodule
